@@ hw/rtl/sha384_pkg.sv @@
// Shared types, constants and round functions of the SHA-384 hash engine.
package sha384_pkg;

  localparam int WordW   = 64;
  localparam int BlkDepth = 16;
  localparam int CvDepth  = 8;
  localparam int Rounds   = 80;
  localparam int DigestWords = 6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FIN, ST_OUT_RD, ST_OUT_WR
  } state_t;

  typedef enum logic [1:0] {
    PS_PAD, PS_ZERO, PS_LENHI, PS_LENLO
  } pad_stage_t;

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
    rotr64 = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] iv_word(input logic [2:0] i);
    case (i)
      3'd0:    iv_word = 64'hcbbb9d5dc1059ed8;
      3'd1:    iv_word = 64'h629a292a367cd507;
      3'd2:    iv_word = 64'h9159015a3070dd17;
      3'd3:    iv_word = 64'h152fecd8f70e5939;
      3'd4:    iv_word = 64'h67332667ffc00b31;
      3'd5:    iv_word = 64'h8eb44a8768581511;
      3'd6:    iv_word = 64'hdb0c2e0d64f98fa7;
      default: iv_word = 64'h47b5481dbefa4fa4;
    endcase
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] i);
    case (i)
      7'd0:  round_k = 64'h428a2f98d728ae22; 7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f; 7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538; 7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b; 7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242; 7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = 64'h0;
    endcase
  endfunction

  // Keeps the valid leading bytes of a short final word and appends the marker byte.
  function automatic logic [63:0] pad_short(input logic [63:0] data, input logic [2:0] n);
    logic [63:0] mask;
    logic [63:0] marker;
    logic [6:0]  nbits;
    nbits  = {1'b0, n, 3'b000};
    mask   = (n == 3'd0) ? 64'h0 : (~64'h0 << (7'd64 - nbits));
    marker = 64'h80 << (7'd56 - nbits);
    pad_short = (data & mask) | marker;
  endfunction

endpackage

@@ hw/rtl/sha384_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sha384_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sha384_hash_engine.sv @@
// SHA-384 engine: one message word per transfer, six digest words per message.
// A word that does not fill a block is taken while the engine stays idle. A full
// block is loaded from the block memory, run through the rounds and written back
// to the chain memory; the single round unit sets the pace. Padding pushes the
// marker word, zero words up to the length words, then the two length words, and
// each digest word is read from the chain memory, then offered once the output is free.
// Reset (rst, synchronous) restores the initial chaining values at once.
module sha384_hash_engine
  import sha384_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], zero fill
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // digest_word[63:0], word_index[66:64], zero fill
  output logic        m_tlast    // last_digest
);

  state_t     state, state_next;
  state_t     ret_state, ret_next;
  pad_stage_t stage, stage_next;

  logic [3:0]  words_held;
  logic [63:0] len_lo, len_hi;
  logic [4:0]  cnt;
  logic [4:0]  cnt_m1;
  logic [6:0]  rnd;
  logic [2:0]  oidx;
  logic [63:0] pad_word;
  logic [63:0] v [CvDepth];
  logic [63:0] w [BlkDepth];
  logic [7:0]  cv_valid;
  logic        cv_rd_valid;
  logic [2:0]  cv_raddr_q;

  logic        push;
  logic [63:0] push_data;
  logic        s_acc;
  logic [3:0]  n_raw;
  logic [3:0]  n_clamp;
  logic        out_load;

  logic        blk_we;
  logic [3:0]  blk_raddr;
  logic [63:0] blk_rdata;
  logic        cv_we;
  logic [2:0]  cv_waddr, cv_raddr;
  logic [63:0] cv_wdata, cv_rdata, cv_data;

  logic [63:0] t1, t2, w_new;

  assign s_acc   = s_tvalid && s_tready;
  assign n_raw   = s_tdata[67:64];
  assign n_clamp = n_raw[3] ? 4'd8 : n_raw;
  assign cnt_m1  = cnt - 5'd1;
  assign cv_data = cv_rd_valid ? cv_rdata : iv_word(cv_raddr_q);

  sha384_ram #(.WIDTH(64), .DEPTH(BlkDepth)) u_blk_ram (
    .clk  (clk),
    .we   (blk_we),
    .waddr(words_held),
    .wdata(push_data),
    .raddr(blk_raddr),
    .rdata(blk_rdata)
  );

  sha384_ram #(.WIDTH(64), .DEPTH(CvDepth)) u_cv_ram (
    .clk  (clk),
    .we   (cv_we),
    .waddr(cv_waddr),
    .wdata(cv_wdata),
    .raddr(cv_raddr),
    .rdata(cv_rdata)
  );

  // One compression round and one message schedule step.
  always_comb begin
    t1 = v[7] + (rotr64(v[4], 14) ^ rotr64(v[4], 18) ^ rotr64(v[4], 41))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w[0];
    t2 = (rotr64(v[0], 28) ^ rotr64(v[0], 34) ^ rotr64(v[0], 39))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = (rotr64(w[14], 19) ^ rotr64(w[14], 61) ^ (w[14] >> 6)) + w[9]
          + (rotr64(w[1], 1) ^ rotr64(w[1], 8) ^ (w[1] >> 7)) + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      stage     <= PS_PAD;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      stage     <= stage_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    stage_next = stage;
    s_tready   = 1'b0;
    push       = 1'b0;
    push_data  = 64'h0;
    blk_raddr  = cnt[3:0];
    cv_raddr   = cnt[2:0];
    cv_we      = 1'b0;
    cv_waddr   = cnt_m1[2:0];
    cv_wdata   = cv_data + v[cnt_m1[2:0]];
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc) begin
          push      = !s_tlast || (n_clamp == 4'd8);
          push_data = s_tdata[63:0];
          if (s_tlast) begin
            stage_next = PS_PAD;
            ret_next   = ST_PAD;
            state_next = ST_PAD;
          end else begin
            ret_next = ST_IDLE;
          end
          if (push && words_held == 4'd15) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_PAD: begin
        case (stage)
          PS_PAD: begin
            push       = 1'b1;
            push_data  = pad_word;
            stage_next = PS_ZERO;
          end
          PS_ZERO: begin
            if (words_held == 4'd14) begin
              stage_next = PS_LENHI;
            end else begin
              push = 1'b1;
            end
          end
          PS_LENHI: begin
            push       = 1'b1;
            push_data  = len_hi;
            stage_next = PS_LENLO;
          end
          default: begin
            push      = 1'b1;
            push_data = len_lo;
          end
        endcase
        if (push && words_held == 4'd15) begin
          state_next = ST_LOAD;
          ret_next   = (stage == PS_LENLO) ? ST_OUT_RD : ST_PAD;
        end
      end
      ST_LOAD: begin
        if (cnt == 5'd16) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 7'(Rounds - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cv_we = (cnt != 5'd0);
        if (cnt == 5'd8) begin
          state_next = ret_state;
        end
      end
      ST_OUT_RD: begin
        cv_raddr   = oidx;
        state_next = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        cv_raddr = oidx;
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = (oidx == 3'(DigestWords - 1)) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    blk_we = push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_held <= 4'd0;
      len_lo     <= 64'h0;
      len_hi     <= 64'h0;
      cnt        <= 5'd0;
      rnd        <= 7'd0;
      oidx       <= 3'd0;
      cv_valid   <= 8'h0;
      m_tvalid   <= 1'b0;
    end else begin
      if (push) begin
        words_held <= words_held + 4'd1;
      end
      if (s_acc) begin
        {len_hi, len_lo} <= {len_hi, len_lo}
                          + (s_tlast ? {121'h0, n_clamp, 3'b000} : 128'd64);
      end
      case (state)
        ST_LOAD: cnt <= (cnt == 5'd16) ? 5'd0 : cnt + 5'd1;
        ST_ROUND: rnd <= (rnd == 7'(Rounds - 1)) ? 7'd0 : rnd + 7'd1;
        ST_FIN: cnt <= (cnt == 5'd8) ? 5'd0 : cnt + 5'd1;
        default: ;
      endcase
      if (cv_we) begin
        cv_valid[cv_waddr] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        if (oidx == 3'(DigestWords - 1)) begin
          // Message done: back to the initial values for the next one.
          oidx     <= 3'd0;
          cv_valid <= 8'h0;
          len_lo   <= 64'h0;
          len_hi   <= 64'h0;
        end else begin
          oidx <= oidx + 3'd1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cv_rd_valid <= cv_valid[cv_raddr];
    cv_raddr_q  <= cv_raddr;
    if (s_acc && s_tlast) begin
      pad_word <= (n_clamp == 4'd8) ? 64'h8000000000000000
                                    : pad_short(s_tdata[63:0], n_clamp[2:0]);
    end
    if (out_load) begin
      m_tdata <= {5'b0, oidx, cv_data};
      m_tlast <= (oidx == 3'(DigestWords - 1));
    end
    case (state)
      ST_LOAD: begin
        if (cnt != 5'd0) begin
          for (int i = 0; i < BlkDepth - 1; i++) begin
            w[i] <= w[i + 1];
          end
          w[BlkDepth - 1] <= blk_rdata;
        end
        if (cnt != 5'd0 && cnt <= 5'd8) begin
          v[cnt_m1[2:0]] <= cv_data;
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < BlkDepth - 1; i++) begin
          w[i] <= w[i + 1];
        end
        w[BlkDepth - 1] <= w_new;
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> rnd < 7'(Rounds))
    else $error("round counter out of range");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[66:64] == 3'(DigestWords - 1))
    else $error("last digest word with wrong index");

  a_fin_return: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && cnt == 5'd8 |=> state == ST_IDLE || state == ST_PAD
                                       || state == ST_OUT_RD)
    else $error("bad return after compression");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> !s_tready && !blk_we)
    else $error("input taken during block load");

endmodule
